// ----- src/rrt_pkg.sv -----
// ----------------------------------------------------------------------------
// rrt_pkg
// Shared types and constants of the 2-D random tree extension block.
// ----------------------------------------------------------------------------
package rrt_pkg;

  localparam int MAX_NODES     = 1024;
  localparam int MAX_OBSTACLES = 16;

  localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NODE_CW = $clog2(MAX_NODES + 1);
  localparam int OBS_AW  = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int SCAN_MAX = (MAX_NODES > MAX_OBSTACLES) ? MAX_NODES : MAX_OBSTACLES;
  localparam int SCAN_CW  = $clog2(SCAN_MAX + 1);

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_EXTEND  = 2'd2
  } cmd_code_t;

  typedef enum logic [2:0] {
    RS_ADDED   = 3'd0,
    RS_BLOCKED = 3'd1,
    RS_FULL    = 3'd2,
    RS_ZERO    = 3'd3,
    RS_DONE    = 3'd4
  } res_status_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_STEP      = 3'd0,
    REG_GOAL_RAD  = 3'd1,
    REG_CLEARANCE = 3'd2,
    REG_GOAL_X    = 3'd3,
    REG_GOAL_Y    = 3'd4,
    REG_OBS_COUNT = 3'd5,
    REG_OWN_SLOT  = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SM_NODE = 2'd0,
    SM_OBS  = 2'd1,
    SM_GOAL = 2'd2
  } scan_mode_t;

  typedef enum logic [2:0] {
    K_PLACED  = 3'd0,
    K_DONE    = 3'd1,
    K_EMPTY   = 3'd2,
    K_FULL    = 3'd3,
    K_ZERO    = 3'd4,
    K_BLOCKED = 3'd5,
    K_ADDED   = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_NSCAN, S_FETCH, S_FETCHW, S_ADIFF, S_ASQ, S_AMUL,
    S_DIVS, S_DIV, S_SQS, S_SQRT, S_ASTORE, S_OSCAN, S_GSCAN, S_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  slot;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        toward_goal;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  node_index;
    logic [9:0]  parent_index;
    logic [15:0] node_x;
    logic [15:0] node_y;
    logic        reached_goal;
  } out_item_t;

  typedef struct packed {
    logic       capture;
    logic       scan_start;
    scan_mode_t scan_mode;
    logic       fetch_rd;
    logic       fetch_cap;
    logic       axis;
    logic       diff_ld;
    logic       sq_ld;
    logic       mul_ld;
    logic       div_start;
    logic       sqrt_start;
    logic       coord_ld;
    logic       finish;
    kind_t      kind;
  } cmd_t;

  typedef struct packed {
    logic [1:0] item_cmd;
    logic       size_zero;
    logic       size_full;
    logic       scan_done;
    logic       len_zero;
    logic       div_busy;
    logic       sq_busy;
    logic       blocked;
  } sts_t;

endpackage

// ----- src/rrt_ram.sv -----
// ----------------------------------------------------------------------------
// rrt_ram
// Generic memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/rrt_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrt_ctrl
// Sequencer: takes one item at a time; an extend steps through scan, step, obstacle and goal phases.
// ----------------------------------------------------------------------------
module rrt_ctrl
  import rrt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  kind_t  kind_r, kind_nxt;
  logic   axis_r, axis_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= K_DONE;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd           = '0;
    cmd.scan_mode = SM_NODE;
    cmd.kind      = kind_r;
    cmd.axis      = axis_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (cmd_code_t'(sts.item_cmd))
          CMD_RESTART: begin
            kind_nxt  = K_PLACED;
            state_nxt = S_RESP;
          end
          CMD_EXTEND: begin
            if (sts.size_zero) begin
              kind_nxt  = K_EMPTY;
              state_nxt = S_RESP;
            end else if (sts.size_full) begin
              kind_nxt  = K_FULL;
              state_nxt = S_RESP;
            end else begin
              cmd.scan_start = 1'b1;
              cmd.scan_mode  = SM_NODE;
              state_nxt      = S_NSCAN;
            end
          end
          default: begin
            kind_nxt  = K_DONE;
            state_nxt = S_RESP;
          end
        endcase
      end
      S_NSCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch_rd = 1'b1;
        state_nxt    = S_FETCHW;
      end
      S_FETCHW: begin
        cmd.fetch_cap = 1'b1;
        if (sts.len_zero) begin
          kind_nxt  = K_ZERO;
          state_nxt = S_RESP;
        end else begin
          axis_nxt  = 1'b0;
          state_nxt = S_ADIFF;
        end
      end
      S_ADIFF: begin
        cmd.diff_ld = 1'b1;
        state_nxt   = S_ASQ;
      end
      S_ASQ: begin
        cmd.sq_ld = 1'b1;
        state_nxt = S_AMUL;
      end
      S_AMUL: begin
        cmd.mul_ld = 1'b1;
        state_nxt  = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_SQS;
        end
      end
      S_SQS: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = S_SQRT;
      end
      S_SQRT: begin
        if (!sts.sq_busy) begin
          state_nxt = S_ASTORE;
        end
      end
      S_ASTORE: begin
        cmd.coord_ld = 1'b1;
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = S_ADIFF;
        end else begin
          cmd.scan_start = 1'b1;
          cmd.scan_mode  = SM_OBS;
          state_nxt      = S_OSCAN;
        end
      end
      S_OSCAN: begin
        if (sts.scan_done) begin
          if (sts.blocked) begin
            kind_nxt  = K_BLOCKED;
            state_nxt = S_RESP;
          end else begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SM_GOAL;
            state_nxt      = S_GSCAN;
          end
        end
      end
      S_GSCAN: begin
        if (sts.scan_done) begin
          kind_nxt  = K_ADDED;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/rrt_dp.sv -----
// ----------------------------------------------------------------------------
// rrt_dp
// Datapath: node memory, obstacle slots, distance pipeline, step divider
// and square root, configuration registers and result register.
// ----------------------------------------------------------------------------
module rrt_dp
  import rrt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  cmd_t              cmd,
  output sts_t              sts,
  output out_item_t         out_data
);

  // configuration
  logic [15:0] step_r, grad_r, clr_r, gx_r, gy_r;
  logic [4:0]  ocnt_r;
  logic [3:0]  own_r;
  logic [31:0] s2q_r, c2_r, r2_r;

  // item and tree state
  in_item_t            item_r;
  logic [15:0]         tx_r, ty_r;
  logic [NODE_CW-1:0]  size_r, size_nxt;
  logic [15:0]         obs_x_r [MAX_OBSTACLES];
  logic [15:0]         obs_y_r [MAX_OBSTACLES];

  // scan issue
  logic               issuing_r, issuing_nxt;
  logic [SCAN_CW-1:0] k_r, k_nxt, n_r, n_nxt, n_start;
  scan_mode_t         mode_r, mode_nxt;
  logic               issue_v;
  logic [31:0]        nobs;

  // distance pipeline
  logic               s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic [SCAN_CW-1:0] s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r;
  logic [15:0]        s1_ox_r, s1_oy_r;
  logic [15:0]        ax, ay, bx, by;
  logic [15:0]        s2_dx_r, s2_dy_r;
  logic [31:0]        s3_qx_r, s3_qy_r;
  logic [32:0]        s4_sum_r;
  logic [32:0]        best_d_r;
  logic [NODE_AW-1:0] best_i_r;
  logic               blocked_r, reached_r;

  // step computation
  logic [15:0] src_x_r, src_y_r, ad_r;
  logic [31:0] ad2_r;
  logic [63:0] num_r;
  logic [32:0] rem_r;
  logic [63:0] quo_r;
  logic [6:0]  dcnt_r;
  logic        div_busy_r;
  logic [33:0] div_sh;
  logic [31:0] sv_r, sr_r, sbit_r, sq_sum;
  logic        sq_busy_r;
  logic [15:0] nx_r, ny_r;
  logic [15:0] ax_t, ax_s, q16, coord;
  logic [16:0] up_sum;

  // memory
  logic               ram_we;
  logic [NODE_AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]        ram_wdata, ram_rdata;

  out_item_t out_r, out_nxt;

  rrt_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_we    = cmd.finish && (cmd.kind == K_PLACED || cmd.kind == K_ADDED);
  assign ram_waddr = (cmd.kind == K_ADDED) ? size_r[NODE_AW-1:0] : '0;
  assign ram_wdata = (cmd.kind == K_ADDED) ? {nx_r, ny_r} : {item_r.pos_x, item_r.pos_y};
  assign ram_raddr = cmd.fetch_rd ? best_i_r : k_r[NODE_AW-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      grad_r <= '0;
      clr_r  <= '0;
      gx_r   <= '0;
      gy_r   <= '0;
      ocnt_r <= '0;
      own_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STEP:      step_r <= cfg_data;
        REG_GOAL_RAD:  grad_r <= cfg_data;
        REG_CLEARANCE: clr_r  <= cfg_data;
        REG_GOAL_X:    gx_r   <= cfg_data;
        REG_GOAL_Y:    gy_r   <= cfg_data;
        REG_OBS_COUNT: ocnt_r <= cfg_data[4:0];
        REG_OWN_SLOT:  own_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s2q_r <= step_r * step_r;
    c2_r  <= clr_r * clr_r;
    r2_r  <= grad_r * grad_r;
  end

  // item capture and obstacle load
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
      tx_r   <= in_data.toward_goal ? gx_r : in_data.pos_x;
      ty_r   <= in_data.toward_goal ? gy_r : in_data.pos_y;
    end
    if (cmd.finish && cmd.kind == K_DONE && cmd_code_t'(item_r.command) == CMD_LOAD
        && 32'(item_r.slot) < MAX_OBSTACLES) begin
      obs_x_r[OBS_AW'(item_r.slot)] <= item_r.pos_x;
      obs_y_r[OBS_AW'(item_r.slot)] <= item_r.pos_y;
    end
  end

  always_comb begin
    size_nxt = size_r;
    if (cmd.finish && cmd.kind == K_PLACED) begin
      size_nxt = NODE_CW'(1);
    end else if (cmd.finish && cmd.kind == K_ADDED) begin
      size_nxt = size_r + 1'b1;
    end
  end

  // scan issue
  assign nobs = (32'(ocnt_r) > MAX_OBSTACLES) ? MAX_OBSTACLES : 32'(ocnt_r);

  always_comb begin
    case (cmd.scan_mode)
      SM_NODE: n_start = SCAN_CW'(size_r);
      SM_OBS:  n_start = SCAN_CW'(nobs);
      default: n_start = SCAN_CW'(1);
    endcase
  end

  assign issue_v = issuing_r && !(mode_r == SM_OBS && 32'(k_r) == 32'(own_r));

  always_comb begin
    issuing_nxt = issuing_r;
    k_nxt       = k_r;
    n_nxt       = n_r;
    mode_nxt    = mode_r;
    if (cmd.scan_start) begin
      issuing_nxt = (n_start != '0);
      k_nxt       = '0;
      n_nxt       = n_start;
      mode_nxt    = cmd.scan_mode;
    end else if (issuing_r) begin
      k_nxt = k_r + 1'b1;
      if (k_r == n_r - 1'b1) begin
        issuing_nxt = 1'b0;
      end
    end
  end

  // distance pipeline: operands, absolute differences, squares, sum
  assign ax = (mode_r == SM_NODE) ? ram_rdata[31:16] : s1_ox_r;
  assign ay = (mode_r == SM_NODE) ? ram_rdata[15:0]  : s1_oy_r;
  assign bx = (mode_r == SM_NODE) ? tx_r : nx_r;
  assign by = (mode_r == SM_NODE) ? ty_r : ny_r;

  always_ff @(posedge clk) begin
    s1_tag_r <= k_r;
    s1_ox_r  <= (mode_r == SM_GOAL) ? gx_r : obs_x_r[k_r[OBS_AW-1:0]];
    s1_oy_r  <= (mode_r == SM_GOAL) ? gy_r : obs_y_r[k_r[OBS_AW-1:0]];
    s2_tag_r <= s1_tag_r;
    s2_dx_r  <= (ax > bx) ? ax - bx : bx - ax;
    s2_dy_r  <= (ay > by) ? ay - by : by - ay;
    s3_tag_r <= s2_tag_r;
    s3_qx_r  <= s2_dx_r * s2_dx_r;
    s3_qy_r  <= s2_dy_r * s2_dy_r;
    s4_tag_r <= s3_tag_r;
    s4_sum_r <= {1'b0, s3_qx_r} + {1'b0, s3_qy_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r <= 1'b0;
      k_r       <= '0;
      n_r       <= '0;
      mode_r    <= SM_NODE;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      s4_v_r    <= 1'b0;
      size_r    <= '0;
    end else begin
      issuing_r <= issuing_nxt;
      k_r       <= k_nxt;
      n_r       <= n_nxt;
      mode_r    <= mode_nxt;
      s1_v_r    <= issue_v;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      s4_v_r    <= s3_v_r;
      size_r    <= size_nxt;
    end
  end

  // nearest node, obstacle hit and goal test
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      blocked_r <= 1'b0;
      reached_r <= 1'b0;
    end else if (s4_v_r) begin
      unique case (mode_r)
        SM_NODE: begin
          if (s4_tag_r == '0 || s4_sum_r < best_d_r) begin
            best_d_r <= s4_sum_r;
            best_i_r <= s4_tag_r[NODE_AW-1:0];
          end
        end
        SM_OBS: begin
          if (s4_sum_r <= {1'b0, c2_r}) begin
            blocked_r <= 1'b1;
          end
        end
        default: begin
          reached_r <= (s4_sum_r < {1'b0, r2_r});
        end
      endcase
    end
  end

  // step along one axis: |d| * step / length, rounded down
  assign ax_t = cmd.axis ? ty_r : tx_r;
  assign ax_s = cmd.axis ? src_y_r : src_x_r;

  always_ff @(posedge clk) begin
    if (cmd.fetch_cap) begin
      src_x_r <= ram_rdata[31:16];
      src_y_r <= ram_rdata[15:0];
    end
    if (cmd.diff_ld) begin
      ad_r <= (ax_t > ax_s) ? ax_t - ax_s : ax_s - ax_t;
    end
    if (cmd.sq_ld) begin
      ad2_r <= ad_r * ad_r;
    end
    if (cmd.mul_ld) begin
      num_r <= ad2_r * s2q_r;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign div_sh = {rem_r, quo_r[63]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      dcnt_r     <= '0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
      dcnt_r     <= 7'd64;
    end else if (div_busy_r) begin
      dcnt_r <= dcnt_r - 1'b1;
      if (dcnt_r == 7'd1) begin
        div_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= num_r;
    end else if (div_busy_r) begin
      if (div_sh >= {1'b0, best_d_r}) begin
        rem_r <= 33'(div_sh - {1'b0, best_d_r});
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= div_sh[32:0];
        quo_r <= {quo_r[62:0], 1'b0};
      end
    end
  end

  // digit-by-digit square root, two radicand bits per cycle
  assign sq_sum = sr_r + sbit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sq_busy_r <= 1'b1;
    end else if (sq_busy_r && sbit_r == 32'd1) begin
      sq_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sv_r   <= quo_r[31:0];
      sr_r   <= '0;
      sbit_r <= 32'h4000_0000;
    end else if (sq_busy_r) begin
      if (sv_r >= sq_sum) begin
        sv_r <= sv_r - sq_sum;
        sr_r <= (sr_r >> 1) + sbit_r;
      end else begin
        sr_r <= sr_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
    end
  end

  // new coordinate, saturated to the field
  assign q16    = sr_r[15:0];
  assign up_sum = {1'b0, ax_s} + {1'b0, q16};

  always_comb begin
    if (ax_t >= ax_s) begin
      coord = up_sum[16] ? 16'hFFFF : up_sum[15:0];
    end else begin
      coord = (q16 > ax_s) ? 16'd0 : ax_s - q16;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.coord_ld) begin
      if (cmd.axis) begin
        ny_r <= coord;
      end else begin
        nx_r <= coord;
      end
    end
  end

  // result register
  always_comb begin
    out_nxt = '0;
    case (cmd.kind)
      K_PLACED: begin
        out_nxt.status = RS_DONE;
        out_nxt.node_x = item_r.pos_x;
        out_nxt.node_y = item_r.pos_y;
      end
      K_EMPTY: begin
        out_nxt.status = RS_BLOCKED;
      end
      K_FULL: begin
        out_nxt.status = RS_FULL;
      end
      K_ZERO: begin
        out_nxt.status       = RS_ZERO;
        out_nxt.parent_index = 10'(best_i_r);
        out_nxt.node_x       = src_x_r;
        out_nxt.node_y       = src_y_r;
      end
      K_BLOCKED: begin
        out_nxt.status       = RS_BLOCKED;
        out_nxt.parent_index = 10'(best_i_r);
        out_nxt.node_x       = nx_r;
        out_nxt.node_y       = ny_r;
      end
      K_ADDED: begin
        out_nxt.status       = RS_ADDED;
        out_nxt.node_index   = 10'(size_r);
        out_nxt.parent_index = 10'(best_i_r);
        out_nxt.node_x       = nx_r;
        out_nxt.node_y       = ny_r;
        out_nxt.reached_goal = reached_r;
      end
      default: begin
        out_nxt.status = RS_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  assign sts.item_cmd  = item_r.command;
  assign sts.size_zero = (size_r == '0);
  assign sts.size_full = (32'(size_r) >= MAX_NODES);
  assign sts.scan_done = !issuing_r && !s1_v_r && !s2_v_r && !s3_v_r && !s4_v_r;
  assign sts.len_zero  = (best_d_r == '0);
  assign sts.div_busy  = div_busy_r;
  assign sts.sq_busy   = sq_busy_r;
  assign sts.blocked   = blocked_r;

endmodule

// ----- src/rrt_tree_extend.sv -----
// ----------------------------------------------------------------------------
// rrt_tree_extend
// 2-D random tree extension in field units: restart, obstacle load, extend.
//
//   channel  ports                            transfer when
//   input    in_valid, in_stall, in_data      in_valid && !in_stall
//   result   out_valid, out_stall, out_data   out_valid && !out_stall
//   config   cfg_we, cfg_index, cfg_data      cfg_we
//
// An extend runs a nearest-node scan that reads one node a cycle from the
// node memory, then for each axis a divide and a square root, and then
// checks obstacles one a cycle. One item is in work at a time; a finished
// result waits in the output register while the next item is taken.
// Reset is synchronous and empties the tree.
// ----------------------------------------------------------------------------
module rrt_tree_extend
  import rrt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  rrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rrt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
